/* rtl/core/es2c_pkg.sv */
// ----------------------------------------------------------------------------
// es2c_pkg
// Shared types, constants and small lookup functions for the epoch seconds
// to calendar converter.
// ----------------------------------------------------------------------------
package es2c_pkg;

  localparam int UnixWidth   = 32;
  localparam int OffsetWidth = 17;
  localparam int YearWidth   = 12;
  localparam int MonthWidth  = 4;
  localparam int DayWidth    = 5;
  localparam int HourWidth   = 5;
  localparam int MinuteWidth = 6;
  localparam int SecondWidth = 6;

  localparam logic signed [OffsetWidth-1:0] OffsetReset = 17'sd28800;

  localparam int SecPerDay    = 86400;
  localparam int SecPerHour   = 3600;
  localparam int SecPerMinute = 60;

  // one day of bias keeps local time non-negative down to 1969-12-31
  localparam int BiasSecs = SecPerDay;

  // seconds / 86400 = (seconds >> 7) / 675, the latter by reciprocal
  localparam int            DayPreShift = 7;
  localparam int            DayRecipSh  = 36;
  localparam logic [26:0]   DayRecip    = 27'd101806633;

  // day 0 (1969-12-31) counted from 1968-03-01, start of a four-year group
  localparam logic [15:0]   MarchBaseDays = 16'd670;
  localparam int            MarchBaseYear = 1968;
  // 2100-03-01 counted from 1968-03-01; 2100 has no leap day
  localparam logic [15:0]   Mar2100Days   = 16'd48212;

  localparam int            DaysPerQuad  = 1461;
  localparam int            DaysPerYear  = 365;
  localparam int            QuadRecipSh  = 27;
  localparam logic [16:0]   QuadRecip    = 17'd91868;

  localparam logic [3:0]    FirstJanMp   = 4'd10;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  // first day of each month within a year that starts on March 1
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] month_of(input logic [8:0] doy);
    logic [3:0] mp;
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy >= month_start(4'(i))) mp = 4'(i);
    end
    return mp;
  endfunction

  function automatic logic [HourWidth-1:0] hour_of(input logic [16:0] sod);
    logic [HourWidth-1:0] h;
    h = '0;
    for (int i = 1; i < 24; i++) begin
      if (sod >= 17'(i * SecPerHour)) h = HourWidth'(i);
    end
    return h;
  endfunction

  function automatic logic [MinuteWidth-1:0] minute_of(input logic [11:0] soh);
    logic [MinuteWidth-1:0] m;
    m = '0;
    for (int i = 1; i < 60; i++) begin
      if (soh >= 12'(i * SecPerMinute)) m = MinuteWidth'(i);
    end
    return m;
  endfunction

endpackage

/* rtl/core/es2c_time_if.sv */
// ----------------------------------------------------------------------------
// es2c_time_if
// Valid/ready channel carrying one Unix second count.
// ----------------------------------------------------------------------------
interface es2c_time_if;
  logic                              valid;
  logic                              ready;
  logic [es2c_pkg::UnixWidth-1:0]    unix_time;

  modport source (output valid, output unix_time, input ready);
  modport sink   (input valid, input unix_time, output ready);
endinterface

/* rtl/core/es2c_cal_if.sv */
// ----------------------------------------------------------------------------
// es2c_cal_if
// Valid/ready channel carrying one local calendar date and time of day.
// ----------------------------------------------------------------------------
interface es2c_cal_if;
  logic                               valid;
  logic                               ready;
  logic [es2c_pkg::YearWidth-1:0]     year;
  logic [es2c_pkg::MonthWidth-1:0]    month;
  logic [es2c_pkg::DayWidth-1:0]      day;
  logic [es2c_pkg::HourWidth-1:0]     hour;
  logic [es2c_pkg::MinuteWidth-1:0]   minute;
  logic [es2c_pkg::SecondWidth-1:0]   second;

  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input hour, input minute, input second, output ready);
endinterface

/* rtl/core/es2c_days.sv */
// ----------------------------------------------------------------------------
// es2c_days
// Input register, zone offset add and split of local time into a day
// number (from 1968-03-01, 2100 leap day inserted) and second of day.
// ----------------------------------------------------------------------------
module es2c_days (
  input  logic                                    clk,
  input  es2c_pkg::pipe_en_t                      en,
  input  logic [es2c_pkg::UnixWidth-1:0]          unix_time,
  input  logic signed [es2c_pkg::OffsetWidth-1:0] zone_offset_seconds,
  output logic [15:0]                             day_num,
  output logic [16:0]                             sod
);

  logic [es2c_pkg::UnixWidth-1:0] unix_s1;
  logic [32:0]                    t_s2;
  logic [15:0]                    q_s2;

  logic [33:0] local_sum;
  logic [52:0] day_prod;
  logic [32:0] day_secs;
  logic [32:0] sod_full;
  logic [15:0] mar_days;
  logic [15:0] day_num_next;
  logic [16:0] sod_next;

  always_comb begin
    local_sum = {2'b00, unix_s1}
              + {{(34 - es2c_pkg::OffsetWidth){zone_offset_seconds[es2c_pkg::OffsetWidth-1]}},
                 zone_offset_seconds}
              + 34'(es2c_pkg::BiasSecs);
    // quotient is below 2**16, top product bit stays clear
    day_prod  = 53'(local_sum[32:es2c_pkg::DayPreShift]) * 53'(es2c_pkg::DayRecip);
  end

  always_comb begin
    day_secs     = 33'(q_s2) * 33'(es2c_pkg::SecPerDay);
    sod_full     = t_s2 - day_secs;
    sod_next     = sod_full[16:0];
    mar_days     = q_s2 + es2c_pkg::MarchBaseDays;
    // skip over a phantom 2100-02-29 so four-year groups stay uniform
    day_num_next = mar_days + 16'(mar_days >= es2c_pkg::Mar2100Days);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      unix_s1 <= unix_time;
    end
    if (en.s2) begin
      t_s2 <= local_sum[32:0];
      q_s2 <= day_prod[51:36];
    end
    if (en.s3) begin
      day_num <= day_num_next;
      sod     <= sod_next;
    end
  end

endmodule

/* rtl/core/es2c_date.sv */
// ----------------------------------------------------------------------------
// es2c_date
// Day number to year, month and day through four-year groups and a
// cumulative month table.
// ----------------------------------------------------------------------------
module es2c_date (
  input  logic                               clk,
  input  es2c_pkg::pipe_en_t                 en,
  input  logic [15:0]                        day_num,
  output logic [es2c_pkg::YearWidth-1:0]     year,
  output logic [es2c_pkg::MonthWidth-1:0]    month,
  output logic [es2c_pkg::DayWidth-1:0]      day
);

  logic [15:0] dn_s4;
  logic [5:0]  quad_s4;

  logic [32:0] quad_prod;
  logic [15:0] quad_start;
  logic [10:0] day_of_quad;
  logic [1:0]  yoq;
  logic [10:0] year_start;
  logic [8:0]  doy;
  logic [3:0]  mp;

  always_comb begin
    quad_prod = 33'(day_num) * 33'(es2c_pkg::QuadRecip);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      dn_s4   <= day_num;
      quad_s4 <= quad_prod[32:es2c_pkg::QuadRecipSh];
    end
  end

  always_comb begin
    quad_start  = 16'(quad_s4) * 16'(es2c_pkg::DaysPerQuad);
    day_of_quad = 11'(dn_s4 - quad_start);
    yoq         = 2'(day_of_quad >= 11'(es2c_pkg::DaysPerYear))
                + 2'(day_of_quad >= 11'(2 * es2c_pkg::DaysPerYear))
                + 2'(day_of_quad >= 11'(3 * es2c_pkg::DaysPerYear));
    year_start  = 11'(yoq) * 11'(es2c_pkg::DaysPerYear);
    doy         = 9'(day_of_quad - year_start);
    mp          = es2c_pkg::month_of(doy);
    day         = 5'(doy - es2c_pkg::month_start(mp) + 9'd1);
    // january and february belong to the next calendar year
    if (mp < es2c_pkg::FirstJanMp) begin
      month = mp + 4'd3;
    end else begin
      month = mp - 4'd9;
    end
    year = 12'(es2c_pkg::MarchBaseYear) + 12'({quad_s4, 2'b00}) + 12'(yoq)
         + 12'(mp >= es2c_pkg::FirstJanMp);
  end

endmodule

/* rtl/core/es2c_tod.sv */
// ----------------------------------------------------------------------------
// es2c_tod
// Second of day to hour, minute and second by threshold compares.
// ----------------------------------------------------------------------------
module es2c_tod (
  input  logic                               clk,
  input  es2c_pkg::pipe_en_t                 en,
  input  logic [16:0]                        sod,
  output logic [es2c_pkg::HourWidth-1:0]     hour,
  output logic [es2c_pkg::MinuteWidth-1:0]   minute,
  output logic [es2c_pkg::SecondWidth-1:0]   second
);

  logic [es2c_pkg::HourWidth-1:0] hour_next;
  logic [16:0]                    hour_start;
  logic [11:0]                    soh_next;
  logic [11:0]                    soh;
  logic [11:0]                    minute_start;

  always_comb begin
    hour_next  = es2c_pkg::hour_of(sod);
    hour_start = 17'(hour_next) * 17'(es2c_pkg::SecPerHour);
    soh_next   = 12'(sod - hour_start);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      hour <= hour_next;
      soh  <= soh_next;
    end
  end

  always_comb begin
    minute       = es2c_pkg::minute_of(soh);
    minute_start = 12'(minute) * 12'(es2c_pkg::SecPerMinute);
    second       = 6'(soh - minute_start);
  end

endmodule

/* rtl/core/epoch_seconds_to_calendar.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Unix second count to local calendar date and time of day.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out, in order. A result passes the
// input register, days split (reciprocal multiply by 1/86400), day fixup,
// four-year group and hour split, then the output register. Each stage holds
// its own valid bit and only stalls when everything ahead of it is full, so a
// waiting result does not stop new timestamps from entering; one is taken
// every cycle unless all stages are full and held. The zone offset (signed
// seconds, reset +8 h) is added without wrap; the Gregorian rule is exact
// over the whole reachable range 1969..2106. Write the offset only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [es2c_pkg::OffsetWidth-1:0]    cfg_wdata,
  es2c_time_if.sink                           stamp,
  es2c_cal_if.source                          cal
);

  logic signed [es2c_pkg::OffsetWidth-1:0] zone_offset_seconds;

  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;
  es2c_pkg::pipe_en_t en;

  logic [15:0]                        day_num;
  logic [16:0]                        sod;
  logic [es2c_pkg::YearWidth-1:0]     year_next;
  logic [es2c_pkg::MonthWidth-1:0]    month_next;
  logic [es2c_pkg::DayWidth-1:0]      day_next;
  logic [es2c_pkg::HourWidth-1:0]     hour_next;
  logic [es2c_pkg::MinuteWidth-1:0]   minute_next;
  logic [es2c_pkg::SecondWidth-1:0]   second_next;

  logic [es2c_pkg::YearWidth-1:0]     year;
  logic [es2c_pkg::MonthWidth-1:0]    month;
  logic [es2c_pkg::DayWidth-1:0]      day;
  logic [es2c_pkg::HourWidth-1:0]     hour;
  logic [es2c_pkg::MinuteWidth-1:0]   minute;
  logic [es2c_pkg::SecondWidth-1:0]   second;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset_seconds <= es2c_pkg::OffsetReset;
    end else if (cfg_we) begin
      zone_offset_seconds <= $signed(cfg_wdata);
    end
  end

  // a stage can load when it is empty or its contents move on
  always_comb begin
    adv5 = !v5 || cal.ready;
    adv4 = !v4 || adv5;
    adv3 = !v3 || adv4;
    adv2 = !v2 || adv3;
    adv1 = !v1 || adv2;
    en.s1 = adv1;
    en.s2 = adv2;
    en.s3 = adv3;
    en.s4 = adv4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) v1 <= stamp.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  es2c_days u_days (
    .clk                 (clk),
    .en                  (en),
    .unix_time           (stamp.unix_time),
    .zone_offset_seconds (zone_offset_seconds),
    .day_num             (day_num),
    .sod                 (sod)
  );

  es2c_date u_date (
    .clk     (clk),
    .en      (en),
    .day_num (day_num),
    .year    (year_next),
    .month   (month_next),
    .day     (day_next)
  );

  es2c_tod u_tod (
    .clk    (clk),
    .en     (en),
    .sod    (sod),
    .hour   (hour_next),
    .minute (minute_next),
    .second (second_next)
  );

  always_ff @(posedge clk) begin
    if (adv5) begin
      year   <= year_next;
      month  <= month_next;
      day    <= day_next;
      hour   <= hour_next;
      minute <= minute_next;
      second <= second_next;
    end
  end

  assign stamp.ready = adv1;
  assign cal.valid   = v5;
  assign cal.year    = year;
  assign cal.month   = month;
  assign cal.day     = day;
  assign cal.hour    = hour;
  assign cal.minute  = minute;
  assign cal.second  = second;

  // an empty output register means the whole pipe can move
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !v5 |-> stamp.ready)
    else $error("input stalled with empty output register");

  // all stages full and output held: nothing may enter
  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && v5 && !cal.ready) |-> !stamp.ready)
    else $error("input accepted while pipeline full");

  // a delivered result is a real date and time
  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    cal.valid |-> (cal.month >= 4'd1 && cal.month <= 4'd12 &&
                   cal.day >= 5'd1 && cal.day <= 5'd31 &&
                   cal.hour <= 5'd23 && cal.minute <= 6'd59 &&
                   cal.second <= 6'd59 &&
                   cal.year >= 12'd1969 && cal.year <= 12'd2106))
    else $error("calendar result out of range");

  // a result held for the sink keeps its place
  a_hold_until_taken: assert property (@(posedge clk) disable iff (rst)
    (v5 && !cal.ready) |=> (v5 && $stable(year) && $stable(month) && $stable(day)
                            && $stable(hour) && $stable(minute) && $stable(second)))
    else $error("pending result lost or changed");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks epoch_seconds_to_calendar against a local calendar predictor. A
// clocked driver feeds timestamps and zone offset writes from a queue; a
// clocked monitor checks every result transaction in order, field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit = 50000;
  localparam int unsigned ZoneSettle = 8;
  localparam int unsigned HoldAt     = 150;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned CalmFrom   = 250;
  localparam int unsigned CalmTo     = 330;
  localparam int unsigned TailCycles = 10;

  typedef enum logic [1:0] {
    OP_STAMP,
    OP_ZONE,
    OP_DRAIN
  } op_kind_t;

  typedef struct {
    op_kind_t                        kind;
    logic [es2c_pkg::UnixWidth-1:0]  value;
  } pending_op_t;

  typedef struct packed {
    logic [es2c_pkg::YearWidth-1:0]    year;
    logic [es2c_pkg::MonthWidth-1:0]   month;
    logic [es2c_pkg::DayWidth-1:0]     day;
    logic [es2c_pkg::HourWidth-1:0]    hour;
    logic [es2c_pkg::MinuteWidth-1:0]  minute;
    logic [es2c_pkg::SecondWidth-1:0]  second;
  } cal_fields_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [es2c_pkg::OffsetWidth-1:0] cfg_wdata;

  es2c_time_if stamp_ch ();
  es2c_cal_if  cal_ch ();

  pending_op_t pending_ops[$];
  cal_fields_t cal_expected[$];

  int unsigned stamps_sent;
  int unsigned results_seen;
  int unsigned error_count;

  logic signed [es2c_pkg::OffsetWidth-1:0] zone_now;

  epoch_seconds_to_calendar u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stamp     (stamp_ch),
    .cal       (cal_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want, input int unsigned idx);
    if (got != want) begin
      report_error($sformatf("result %0d: %s is %0d, expected %0d", idx, name, got, want));
    end
  endtask

  // civil date from a day count that starts on 0000-03-01
  function automatic cal_fields_t local_calendar(
      input logic [es2c_pkg::UnixWidth-1:0]          stamp,
      input logic signed [es2c_pkg::OffsetWidth-1:0] zone);
    longint biased, day_count, sec_of_day, era, day_of_era, year_of_era;
    longint day_of_year, mar_month, yr, mon, dom, hr, mins, secs;
    cal_fields_t r;
    biased      = longint'({32'd0, stamp}) + longint'(zone) + 64'sd719468 * 64'sd86400;
    day_count   = biased / 86400;
    sec_of_day  = biased % 86400;
    era         = day_count / 146097;
    day_of_era  = day_count % 146097;
    year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                   - day_of_era / 146096) / 365;
    yr          = year_of_era + era * 400;
    day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
    mar_month   = (5 * day_of_year + 2) / 153;
    dom         = day_of_year - (153 * mar_month + 2) / 5 + 1;
    mon         = (mar_month < 10) ? mar_month + 3 : mar_month - 9;
    if (mon <= 2) yr = yr + 1;
    hr          = sec_of_day / 3600;
    mins        = (sec_of_day % 3600) / 60;
    secs        = sec_of_day % 60;
    r.year   = yr[es2c_pkg::YearWidth-1:0];
    r.month  = mon[es2c_pkg::MonthWidth-1:0];
    r.day    = dom[es2c_pkg::DayWidth-1:0];
    r.hour   = hr[es2c_pkg::HourWidth-1:0];
    r.minute = mins[es2c_pkg::MinuteWidth-1:0];
    r.second = secs[es2c_pkg::SecondWidth-1:0];
    return r;
  endfunction

  function automatic bit calm_window();
    return stamps_sent >= CalmFrom && stamps_sent < CalmTo;
  endfunction

  function automatic bit take_a_break();
    return !calm_window() && $urandom_range(0, 99) < 17;
  endfunction

  task automatic add_stamp(input logic [es2c_pkg::UnixWidth-1:0] t);
    pending_ops.push_back('{kind: OP_STAMP, value: t});
  endtask

  task automatic add_zone(input logic [es2c_pkg::OffsetWidth-1:0] z);
    pending_ops.push_back('{kind: OP_ZONE,
        value: {{(es2c_pkg::UnixWidth - es2c_pkg::OffsetWidth){1'b0}}, z}});
  endtask

  // mostly random, with weight on the range ends and on local midnight
  function automatic logic [es2c_pkg::UnixWidth-1:0] pick_stamp(
      input logic signed [es2c_pkg::OffsetWidth-1:0] z);
    logic [es2c_pkg::UnixWidth-1:0] t;
    case ($urandom_range(0, 9))
      0, 1: begin
        if ($urandom_range(0, 1) != 0) t = $urandom_range(0, 200000);
        else t = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      end
      2, 3, 4: begin
        t = 32'($urandom_range(0, 49710)) * 32'd86400 - 32'(z)
            + $urandom_range(0, 8) - 32'd4;
      end
      default: t = $urandom;
    endcase
    return t;
  endfunction

  function automatic logic [es2c_pkg::OffsetWidth-1:0] pick_zone(input int unsigned seg);
    logic [es2c_pkg::OffsetWidth-1:0] z;
    logic [31:0]                      raw;
    int                               zi;
    if (seg == 0) begin
      z = es2c_pkg::OffsetReset;
    end else begin
      case ($urandom_range(0, 3))
        0:       z = 17'h10000;
        1:       z = 17'h0FFFF;
        2: begin
          zi = int'($urandom_range(0, 93600)) - 43200;
          z  = zi[es2c_pkg::OffsetWidth-1:0];
        end
        default: begin
          raw = $urandom;
          z   = raw[es2c_pkg::OffsetWidth-1:0];
        end
      endcase
    end
    return z;
  endfunction

  // driver: one decision per edge, each input assigned once
  always @(posedge clk) begin : stamp_driver
    logic                             take;
    logic                             next_valid;
    logic                             next_we;
    logic [es2c_pkg::UnixWidth-1:0]   next_time;
    logic [es2c_pkg::OffsetWidth-1:0] next_wdata;
    int unsigned                      inflight;
    int unsigned                      quiet_cycles;
    if (rst) begin
      stamp_ch.valid <= 1'b0;
      cfg_we         <= 1'b0;
      zone_now       = es2c_pkg::OffsetReset;
      quiet_cycles   = 0;
    end else begin
      take       = stamp_ch.valid && stamp_ch.ready;
      next_valid = stamp_ch.valid && !take;
      next_we    = 1'b0;
      next_time  = stamp_ch.unix_time;
      next_wdata = cfg_wdata;
      if (take) begin
        cal_expected.push_back(local_calendar(stamp_ch.unix_time, zone_now));
        stamps_sent <= stamps_sent + 1;
      end
      inflight = stamps_sent + int'(take) - results_seen;
      if (inflight == 0 && !next_valid) quiet_cycles = quiet_cycles + 1;
      else quiet_cycles = 0;
      if (!next_valid && pending_ops.size() != 0) begin
        case (pending_ops[0].kind)
          OP_STAMP: begin
            if (!take_a_break()) begin
              next_valid = 1'b1;
              next_time  = pending_ops[0].value;
              void'(pending_ops.pop_front());
            end
          end
          OP_ZONE: begin
            // pipeline must be empty before the offset changes
            if (quiet_cycles >= ZoneSettle) begin
              next_we    = 1'b1;
              next_wdata = pending_ops[0].value[es2c_pkg::OffsetWidth-1:0];
              zone_now   = pending_ops[0].value[es2c_pkg::OffsetWidth-1:0];
              void'(pending_ops.pop_front());
            end
          end
          OP_DRAIN: begin
            if (inflight == 0) void'(pending_ops.pop_front());
          end
          default: void'(pending_ops.pop_front());
        endcase
      end
      stamp_ch.valid     <= next_valid;
      stamp_ch.unix_time <= next_time;
      cfg_we             <= next_we;
      cfg_wdata          <= next_wdata;
    end
  end

  // receiver backpressure, with one long hold-off to fill the pipeline
  always @(posedge clk) begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    if (rst) begin
      cal_ch.ready <= 1'b0;
      hold_left    = 0;
      hold_done    = 1'b0;
    end else if (!hold_done && stamps_sent >= HoldAt) begin
      hold_done    = 1'b1;
      hold_left    = HoldCycles;
      cal_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    = hold_left - 1;
      cal_ch.ready <= 1'b0;
    end else begin
      cal_ch.ready <= calm_window() || $urandom_range(0, 99) >= 17;
    end
  end

  always @(posedge clk) begin : result_monitor
    cal_fields_t want;
    if (!rst && cal_ch.valid && cal_ch.ready) begin
      results_seen <= results_seen + 1;
      if (cal_expected.size() == 0) begin
        report_error($sformatf("result %0d with nothing expected", results_seen));
      end else begin
        want = cal_expected.pop_front();
        check_field("year",   cal_ch.year,   want.year,   results_seen);
        check_field("month",  cal_ch.month,  want.month,  results_seen);
        check_field("day",    cal_ch.day,    want.day,    results_seen);
        check_field("hour",   cal_ch.hour,   want.hour,   results_seen);
        check_field("minute", cal_ch.minute, want.minute, results_seen);
        check_field("second", cal_ch.second, want.second, results_seen);
      end
    end
  end

  initial begin : run_test
    logic signed [es2c_pkg::OffsetWidth-1:0] seg_zone;
    int unsigned                             waited;
    stamps_sent        = 0;
    results_seen       = 0;
    error_count        = 0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    stamp_ch.valid     = 1'b0;
    stamp_ch.unix_time = '0;
    cal_ch.ready       = 1'b0;

    // reset offset: epoch, range top, leap days, year end, 2100 non-leap
    add_stamp(32'd0);
    add_stamp(32'hFFFF_FFFF);
    add_stamp(32'd951782400);
    add_stamp(32'd951868799);
    add_stamp(32'd4107542399);
    add_stamp(32'd4107542400);
    add_stamp(32'd68083200);
    add_stamp(32'd946684799);
    add_stamp(32'h8000_0000);
    add_stamp(32'h5555_5555);
    add_stamp(32'hAAAA_AAAA);
    // most negative pattern: local time before the epoch
    add_zone(17'h10000);
    add_stamp(32'd0);
    add_stamp(32'd1);
    add_stamp(32'd65535);
    add_stamp(32'hFFFF_FFFF);
    // most positive pattern: carry past the 32-bit limit
    add_zone(17'h0FFFF);
    add_stamp(32'hFFFF_FFFF);
    add_stamp(32'hFFFF_0000);
    add_stamp(32'd0);
    add_zone(17'h00000);
    add_stamp(32'd0);
    add_stamp(32'hFFFF_FFFF);
    add_stamp(32'd4107542400);
    add_zone(17'(-43200));
    add_stamp(32'd0);
    add_stamp(32'd43199);
    add_zone(17'd50400);
    add_stamp(32'hFFFF_FFFF);

    for (int unsigned seg = 0; seg < 8; seg++) begin
      seg_zone = pick_zone(seg);
      add_zone(seg_zone);
      for (int unsigned n = 0; n < 50; n++) begin
        if (seg == 3 && n == 25) pending_ops.push_back('{kind: OP_DRAIN, value: '0});
        add_stamp(pick_stamp(seg_zone));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    waited = 0;
    @(negedge clk);
    while (!(pending_ops.size() == 0 && !stamp_ch.valid && stamps_sent == results_seen)
           && waited < CycleLimit) begin
      @(negedge clk);
      waited++;
    end
    if (waited >= CycleLimit) report_error("timeout waiting for results");
    repeat (TailCycles) @(negedge clk);
    if (cal_expected.size() != 0) begin
      report_error($sformatf("%0d expected results never arrived", cal_expected.size()));
    end
    if (error_count == 0) begin
      $display("epoch_seconds_to_calendar test passed");
    end else begin
      $display("epoch_seconds_to_calendar test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/es2c_pkg.sv
rtl/core/es2c_time_if.sv
rtl/core/es2c_cal_if.sv
rtl/core/es2c_days.sv
rtl/core/es2c_date.sv
rtl/core/es2c_tod.sv
rtl/core/epoch_seconds_to_calendar.sv
tb/testbench.sv
